// ===== design/ltdv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdv_pkg: shared constants for the line-table delta varint encoder
// Field widths and varint byte layout used by the channels and the core.
// ----------------------------------------------------------------------------
package ltdv_pkg;

  // Payload field widths
  localparam int CODE_W = 32;
  localparam int SRC_W  = 31;
  localparam int BYTE_W = 8;

  // Varint byte layout: seven data bits, continuation in the top bit
  localparam int GROUP_W  = 7;
  localparam int CONT_POS = 7;

endpackage

// ===== design/ltdv_entry_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdv_entry_if: line-table entry channel
// valid/ready channel carrying one entry: table start flag and two offsets.
// ----------------------------------------------------------------------------
interface ltdv_entry_if;
  logic                         valid;
  logic                         ready;
  logic                         table_start;
  logic [ltdv_pkg::CODE_W-1:0]  code_offset;
  logic [ltdv_pkg::SRC_W-1:0]   source_offset;

  modport source (output valid, output table_start, output code_offset,
                  output source_offset, input ready);
  modport sink   (input valid, input table_start, input code_offset,
                  input source_offset, output ready);
endinterface

// ===== design/ltdv_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltdv_byte_if: encoded byte channel
// valid/ready channel carrying one varint byte and an end-of-entry flag.
// ----------------------------------------------------------------------------
interface ltdv_byte_if;
  logic                         valid;
  logic                         ready;
  logic [ltdv_pkg::BYTE_W-1:0]  code_byte;
  logic                         entry_last;

  modport source (output valid, output code_byte, output entry_last, input ready);
  modport sink   (input valid, input code_byte, input entry_last, output ready);
endinterface

// ===== design/line_table_delta_varint_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_table_delta_varint_encoder: delta + zigzag + ULEB128 line-table encoder
// Turns each line-table entry into two varints: code-offset delta and
// zigzag-mapped source-offset delta.
// ----------------------------------------------------------------------------
// One entry is taken at a time. After the entry transfer, S_DCODE forms the
// code-offset delta in the shared 32-bit subtractor, then one byte per cycle,
// while the byte sink does not hold ready low, leaves through a 7-bit shift
// of the working register (1 to 5 bytes), then S_DSRC forms the zigzag source
// delta in the same subtractor, then its 1 to 5 bytes follow. The output
// byte sits in its own register, so the next entry is taken while the last
// byte of the previous one still waits. entry_last marks the final byte.
// ----------------------------------------------------------------------------
module line_table_delta_varint_encoder (
  input  logic         clk,
  input  logic         rst,
  ltdv_entry_if.sink   entry,
  ltdv_byte_if.source  bytes
);

  // Sequencer state codes
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DCODE     = 3'd1;
  localparam logic [2:0] S_EMIT_CODE = 3'd2;
  localparam logic [2:0] S_DSRC      = 3'd3;
  localparam logic [2:0] S_EMIT_SRC  = 3'd4;

  localparam int CW = ltdv_pkg::CODE_W;
  localparam int SW = ltdv_pkg::SRC_W;
  localparam int GW = ltdv_pkg::GROUP_W;

  logic [2:0]                  state;
  logic [CW-1:0]               cur_code;
  logic [SW-1:0]               cur_src;
  logic [CW-1:0]               prev_code;
  logic [SW-1:0]               prev_src;
  logic [CW-1:0]               work;
  logic                        byte_valid;
  logic [ltdv_pkg::BYTE_W-1:0] byte_data;
  logic                        byte_last;

  logic                        entry_xfer;
  logic                        slot_free;
  logic                        emitting;
  logic                        load_byte;
  logic                        more;
  logic [CW-1:0]               sub_a;
  logic [CW-1:0]               sub_b;
  logic [CW-1:0]               diff;
  logic [CW-1:0]               zigzag;

  assign entry.ready  = (state == S_IDLE);
  assign entry_xfer   = entry.valid && entry.ready;
  assign bytes.valid      = byte_valid;
  assign bytes.code_byte  = byte_data;
  assign bytes.entry_last = byte_last;

  // Shared subtractor: code delta in S_DCODE, source delta otherwise
  always_comb begin
    if (state == S_DCODE) begin
      sub_a = cur_code;
      sub_b = prev_code;
    end else begin
      sub_a = {1'b0, cur_src};
      sub_b = {1'b0, prev_src};
    end
    diff   = sub_a - sub_b;
    zigzag = {diff[CW-2:0], 1'b0} ^ {CW{diff[CW-1]}};
  end

  // Byte emission control
  assign slot_free = !byte_valid || bytes.ready;
  assign emitting  = (state == S_EMIT_CODE) || (state == S_EMIT_SRC);
  assign load_byte = emitting && slot_free;
  assign more      = |work[CW-1:GW];

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_code <= '0;
      prev_src  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (entry_xfer) begin
            cur_code <= entry.code_offset;
            cur_src  <= entry.source_offset;
            if (entry.table_start) begin
              prev_code <= '0;
              prev_src  <= '0;
            end
            state <= S_DCODE;
          end
        end
        S_DCODE: begin
          work      <= diff;
          prev_code <= cur_code;
          state     <= S_EMIT_CODE;
        end
        S_EMIT_CODE: begin
          if (load_byte) begin
            work <= work >> GW;
            if (!more) begin
              state <= S_DSRC;
            end
          end
        end
        S_DSRC: begin
          work     <= zigzag;
          prev_src <= cur_src;
          state    <= S_EMIT_SRC;
        end
        S_EMIT_SRC: begin
          if (load_byte) begin
            work <= work >> GW;
            if (!more) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (load_byte) begin
      byte_valid <= 1'b1;
    end else if (bytes.ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      byte_data <= {more, work[GW-1:0]};
      byte_last <= (state == S_EMIT_SRC) && !more;
    end
  end

  // A continuation byte never ends an entry
  a_cont_not_last: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.code_byte[ltdv_pkg::CONT_POS]) |-> !bytes.entry_last)
    else $error("continuation byte flagged as entry end");

  // Bytes of the code varint never carry the entry end flag
  a_code_not_last: assert property (@(posedge clk) disable iff (rst)
    (load_byte && state == S_EMIT_CODE) |=> !bytes.entry_last)
    else $error("code varint byte flagged as entry end");

  // A table start clears the previous offsets before the delta is formed
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (entry_xfer && entry.table_start) |=> (prev_code == '0 && prev_src == '0))
    else $error("table start did not clear previous offsets");

  // An entry transfer starts the sequencer in S_DCODE, where no new entry is taken
  a_accept_flow: assert property (@(posedge clk) disable iff (rst)
    entry_xfer |=> (state == S_DCODE && !entry.ready))
    else $error("sequencer did not start on entry transfer");

endmodule
